// File: hw/rtl/aes_pkg.sv
// Shared types, constants and round functions of the AES block cipher.
// Holds the S-box table and the byte-level transforms used by the key
// schedule and the round stages. No dependencies.
package aes_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int NUM_RK     = MAX_ROUNDS + 1;
  localparam int NUM_STAGES = MAX_ROUNDS + 1;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_A = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_D = 3'd4;

  // key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  typedef struct packed {
    logic        op;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_upper;
    logic [63:0] result_lower;
  } aes_out_t;

  typedef struct packed {
    logic         op;
    logic [127:0] st;
  } aes_pipe_t;

  typedef struct packed {
    logic first;
    logic active;
    logic last;
  } aes_stage_ctrl_t;

  typedef logic [NUM_RK-1:0][127:0] aes_rk_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TBL[2047 - 8 * int'(x) -: 8];
  endfunction

  // inverse affine map of the S-box
  function automatic logic [7:0] aff_inv(input logic [7:0] b);
    return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
  endfunction

  // the field inverse equals aff_inv(sbox(y)), so one table serves both ways
  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    return aff_inv(sbox(aff_inv(b)));
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[127 - 8 * i -: 8] = sbox(s[127 - 8 * i -: 8]);
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[127 - 8 * i -: 8] = inv_sbox(s[127 - 8 * i -: 8]);
    return t;
  endfunction

  // byte i sits at bits 127-8i; byte r+4c is row r, column c
  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = s[127 - 8 * (r + 4 * c) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   m2 [4];
    logic [7:0]   m4 [4];
    logic [7:0]   m8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   mb [4];
    logic [7:0]   md [4];
    logic [7:0]   me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127 - 32 * c - 8 * k -: 8];
        m2[k] = xt(a[k]);
        m4[k] = xt(m2[k]);
        m8[k] = xt(m4[k]);
        m9[k] = m8[k] ^ a[k];
        mb[k] = m8[k] ^ m2[k] ^ a[k];
        md[k] = m8[k] ^ m4[k] ^ a[k];
        me[k] = m8[k] ^ m4[k] ^ m2[k];
      end
      t[127 - 32 * c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[119 - 32 * c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[111 - 32 * c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[103 - 32 * c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/aes_key_expand.sv
// Key registers and sequential AES key schedule, one word per cycle.
// Depends on aes_pkg.
module aes_key_expand import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output aes_rk_t     rk_o,
  output logic [1:0]  klen_o,
  output logic        busy_o
);

  logic [1:0]  klen_q, klen_d;
  logic [63:0] kw_q [4];
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [2:0]  ph_q, ph_d;
  logic [7:0]  rcon_q, rcon_d;
  logic [31:0] win_q [8];
  aes_rk_t     rk_q;

  logic [1:0]  len;
  logic [3:0]  nk;
  logic [5:0]  last_word;
  logic [31:0] tmp, new_word, far_word;
  logic        restart;

  always_comb begin
    len = (klen_q == 2'd3) ? KLEN_256 : klen_q;
    case (len)
      KLEN_128: begin nk = 4'd4; last_word = 6'd43; far_word = win_q[3]; end
      KLEN_192: begin nk = 4'd6; last_word = 6'd51; far_word = win_q[5]; end
      default:  begin nk = 4'd8; last_word = 6'd59; far_word = win_q[7]; end
    endcase
  end

  always_comb begin
    tmp    = win_q[0];
    rcon_d = rcon_q;
    if ({2'b00, cnt_q} < {4'd0, nk}) begin
      new_word = cnt_q[0] ? kw_q[cnt_q[2:1]][31:0] : kw_q[cnt_q[2:1]][63:32];
    end else begin
      if (ph_q == 3'd0) begin
        tmp    = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'd0};
        rcon_d = xt(rcon_q);
      end else if (nk == 4'd8 && ph_q == 3'd4) begin
        tmp = sub_word(win_q[0]);
      end
      new_word = far_word ^ tmp;
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i <= REG_KEY_WORD_D);

  always_comb begin
    klen_d = klen_q;
    if (cfg_we_i && cfg_idx_i == REG_KEY_LENGTH) klen_d = cfg_wdata_i[1:0];
    busy_d = busy_q;
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    if (busy_q) begin
      cnt_d  = cnt_q + 6'd1;
      ph_d   = ({1'b0, ph_q} == nk - 4'd1) ? 3'd0 : ph_q + 3'd1;
      busy_d = (cnt_q != last_word);
    end
    if (restart) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ph_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_128;
      busy_q <= 1'b1;
      cnt_q  <= '0;
      ph_q   <= '0;
      rcon_q <= 8'h01;
      for (int i = 0; i < 4; i++) kw_q[i] <= '0;
    end else begin
      klen_q <= klen_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ph_q   <= ph_d;
      if (restart) rcon_q <= 8'h01;
      else if (busy_q) rcon_q <= rcon_d;
      for (int i = 0; i < 4; i++)
        if (cfg_we_i && cfg_idx_i == REG_KEY_WORD_A + 3'(i)) kw_q[i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !restart) begin
      win_q[0] <= new_word;
      for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
      for (int r = 0; r < NUM_RK; r++)
        for (int w = 0; w < 4; w++)
          if (cnt_q == 6'(4 * r + w)) rk_q[r][127 - 32 * w -: 32] <= new_word;
    end
  end

  assign rk_o   = rk_q;
  assign klen_o = len;
  assign busy_o = busy_q;

endmodule

// File: hw/rtl/aes_round_stage.sv
// One registered AES round stage, forward or inverse per item.
// Depends on aes_pkg.
module aes_round_stage import aes_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aes_stage_ctrl_t ctrl_i,
  input  logic [127:0]    key_enc_i,
  input  logic [127:0]    key_dec_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  aes_pipe_t       data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output aes_pipe_t       data_o
);

  logic         valid_q;
  aes_pipe_t    data_q, data_d;
  logic [127:0] key, t;

  always_comb begin
    key    = data_i.op ? key_dec_i : key_enc_i;
    t      = data_i.st;
    data_d = data_i;
    if (ctrl_i.first) begin
      t = data_i.st ^ key;
    end else if (ctrl_i.active) begin
      if (!data_i.op) begin
        t = shift_rows(sub_bytes(data_i.st));
        if (!ctrl_i.last) t = mix_columns(t);
        t = t ^ key;
      end else begin
        t = inv_sub_bytes(inv_shift_rows(data_i.st)) ^ key;
        if (!ctrl_i.last) t = inv_mix_columns(t);
      end
    end
    data_d.st = t;
  end

  // take a new transfer whenever the register is empty or draining
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (ready_o) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/aes_block_cipher.sv
// Top level of the pipelined AES block cipher (128/192/256-bit keys).
// Depends on aes_pkg, aes_key_expand and aes_round_stage.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one block and an encrypt
//   or decrypt selector per transfer; output channel out_valid_o/out_ready_i
//   returns the processed block. Results leave in the order blocks enter.
//   Configuration: cfg_we_i with cfg_idx_i (0 key length, 1..4 key words
//   a..d) and cfg_wdata_i; write only while no block is in flight.
//   Indexes beyond 4 are dropped.
// Key lengths: every key length uses the same stage chain;
//   shorter keys pass through the unused tail stages unchanged.
// Throughput: one block per cycle unless out_ready_i or the key schedule stalls;
//   fifteen round stages (initial key add plus fourteen rounds), one block each.
// Key schedule: after reset and after every accepted key write the round
//   keys are rebuilt one 32-bit word per cycle, 44, 52 or 60 words for
//   128, 192 or 256-bit keys; in_ready_o stays low meanwhile. Reset loads
//   the all-zero 128-bit key.
// Stalls: each stage has its own ready, so when the receiver holds
//   out_ready_i low, blocks close up behind the waiting result and new
//   transfers are still taken until every stage is full. Nothing is lost
//   or repeated.
module aes_block_cipher import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  aes_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output aes_out_t    out_data_o
);

  aes_rk_t    rk;
  logic [1:0] klen;
  logic       busy;

  logic       valid [NUM_STAGES+1];
  logic       ready [NUM_STAGES+1];
  aes_pipe_t  data  [NUM_STAGES+1];

  aes_key_expand u_key (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .rk_o   (rk),
    .klen_o (klen),
    .busy_o (busy)
  );

  // hold the input side while the key schedule runs
  assign valid[0]   = in_valid_i && !busy;
  assign in_ready_o = ready[0] && !busy;
  assign data[0]    = '{op: in_data_i.op, st: {in_data_i.block_upper, in_data_i.block_lower}};

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    // decryption runs the round keys backwards from the last round
    localparam int D128 = (10 - k < 0) ? 0 : 10 - k;
    localparam int D192 = (12 - k < 0) ? 0 : 12 - k;
    localparam int D256 = (14 - k < 0) ? 0 : 14 - k;

    aes_stage_ctrl_t ctrl;
    logic [127:0]    key_dec;
    logic [3:0]      nr;

    always_comb begin
      case (klen)
        KLEN_128: begin nr = 4'd10; key_dec = rk[D128]; end
        KLEN_192: begin nr = 4'd12; key_dec = rk[D192]; end
        default:  begin nr = 4'd14; key_dec = rk[D256]; end
      endcase
      ctrl.first  = (k == 0);
      ctrl.active = (4'(k) <= nr);
      ctrl.last   = (4'(k) == nr);
    end

    aes_round_stage u_stage (
      .clk_i,
      .rst_ni,
      .ctrl_i    (ctrl),
      .key_enc_i (rk[k]),
      .key_dec_i (key_dec),
      .valid_i   (valid[k]),
      .ready_o   (ready[k]),
      .data_i    (data[k]),
      .valid_o   (valid[k+1]),
      .ready_i   (ready[k+1]),
      .data_o    (data[k+1])
    );
  end

  assign ready[NUM_STAGES] = out_ready_i;
  assign out_valid_o       = valid[NUM_STAGES];
  assign out_data_o        = '{result_upper: data[NUM_STAGES].st[127:64],
                               result_lower: data[NUM_STAGES].st[63:0]};

endmodule

// File: hw/rtl/aes_chk.sv
// Port-level checker for the AES block cipher, bound to the top level.
// Depends on aes_pkg.
module aes_chk import aes_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input aes_out_t    out_data_o
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output result changed while stalled");

  // a key write starts the schedule and closes the input
  a_key_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i <= REG_KEY_WORD_D |=> !in_ready_o)
    else $error("input open right after key write");

  // the schedule holds the input closed beyond the point that a_key_busy checks
  a_key_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i <= REG_KEY_WORD_D |=> ##1 !in_ready_o)
    else $error("key schedule ended too early");

endmodule

bind aes_block_cipher aes_chk u_aes_chk (
  .clk_i,
  .rst_ni,
  .cfg_we_i,
  .cfg_idx_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .out_data_o
);
